// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion forms used by the byte array checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and held off while rst_n is low.
`define IBA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and held off while rst_n is low.
`define IBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/iba_pkg.sv =====
// ----------------------------------------------------------------------------
// Insertable byte array package
// Field widths, action codes and the beat types shared by the array modules.
// ----------------------------------------------------------------------------
package iba_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned FILL_W    = 9;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned ACT_W     = 3;
  localparam int unsigned DEPTH_DEF = 256;

  // Capacity register value after reset.
  localparam logic [FILL_W-1:0] CAP_RESET = 9'd256;

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_PUSH   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_POP    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_GET    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_INSERT = 3'd3;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd4;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd5;

  // One request beat.
  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [FILL_W-1:0] position;
    logic [FILL_W-1:0] length;
    logic [BYTE_W-1:0] byte_in;
  } in_t;

  // One result beat.
  typedef struct packed {
    logic              ok;
    logic [BYTE_W-1:0] byte_out;
    logic [FILL_W-1:0] fill;
  } out_t;

  // Result handed from the controller to the output register.
  typedef struct packed {
    logic valid;
    out_t data;
  } ctrl_res_t;

endpackage

// ===== hw/rtl/iba_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-clock RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module iba_ram import iba_pkg::*; #(
  parameter int unsigned WIDTH = BYTE_W,
  parameter int unsigned DEPTH = DEPTH_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/iba_ctrl.sv =====
// ----------------------------------------------------------------------------
// Insertable byte array controller
// Decodes each request, keeps the fill count and runs the byte mover that
// shifts stored bytes up or down through the RAM, one byte per cycle.
// ----------------------------------------------------------------------------
module iba_ctrl import iba_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_t               in_data,
  input  logic [FILL_W-1:0] limit,
  output ctrl_res_t         res,
  output logic              mem_we,
  output logic [AW-1:0]     mem_waddr,
  output logic [BYTE_W-1:0] mem_wdata,
  output logic [AW-1:0]     mem_raddr,
  input  logic [BYTE_W-1:0] mem_rdata
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_FETCH = 4'b0100,
    S_SHIFT = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  in_t               req_r, req_nxt;
  logic [FILL_W-1:0] count_r, count_nxt;
  logic [FILL_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [FILL_W-1:0] wr_idx_r, wr_idx_nxt;
  logic [FILL_W-1:0] rem_r, rem_nxt;
  logic              pend_r, pend_nxt;
  logic              up_r, up_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;

  logic [FILL_W-1:0] count_succ;
  logic [FILL_W:0]   span_end;
  logic [FILL_W-1:0] ins_moves;
  logic [FILL_W-1:0] rm_moves;
  logic [FILL_W-1:0] rd_i;
  logic [FILL_W-1:0] wa_i;
  logic              fin;
  logic              fin_ok;
  logic [BYTE_W-1:0] fin_byte;

  assign busy = (state_r != S_IDLE);

  // Fill count after a successful action.
  always_comb begin
    case (req_r.action) inside
      ACT_PUSH, ACT_INSERT: count_succ = count_r + 1'b1;
      ACT_POP:              count_succ = count_r - 1'b1;
      ACT_REMOVE:           count_succ = count_r - req_r.length;
      ACT_CLEAR:            count_succ = '0;
      default:              count_succ = count_r;
    endcase
  end

  // Range arithmetic for insert and remove.
  assign span_end  = {1'b0, req_r.position} + {1'b0, req_r.length};
  assign ins_moves = count_r - req_r.position;
  assign rm_moves  = count_r - span_end[FILL_W-1:0];

  // Sequencer and byte mover.
  always_comb begin
    state_nxt  = state_r;
    req_nxt    = req_r;
    count_nxt  = count_r;
    rd_idx_nxt = rd_idx_r;
    wr_idx_nxt = wr_idx_r;
    rem_nxt    = rem_r;
    pend_nxt   = 1'b0;
    up_nxt     = up_r;
    byte_nxt   = byte_r;
    mem_we     = 1'b0;
    wa_i       = wr_idx_r;
    mem_wdata  = mem_rdata;
    rd_i       = rd_idx_r;
    fin        = 1'b0;
    fin_ok     = 1'b0;
    fin_byte   = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt   = in_data;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        case (req_r.action)
          ACT_PUSH: begin
            fin = 1'b1;
            if (count_r < limit) begin
              mem_we    = 1'b1;
              wa_i      = count_r;
              mem_wdata = req_r.byte_in;
              fin_ok    = 1'b1;
            end
          end
          ACT_POP: begin
            if (count_r != '0) begin
              // Read the front byte, then move the rest down by one.
              rd_i       = '0;
              rem_nxt    = count_r - 1'b1;
              rd_idx_nxt = FILL_W'(1);
              wr_idx_nxt = '0;
              up_nxt     = 1'b0;
              state_nxt  = S_FETCH;
            end else begin
              fin = 1'b1;
            end
          end
          ACT_GET: begin
            if (req_r.position < count_r) begin
              rd_i      = req_r.position;
              rem_nxt   = '0;
              state_nxt = S_FETCH;
            end else begin
              fin = 1'b1;
            end
          end
          ACT_INSERT: begin
            if ((req_r.position <= count_r) && (count_r < limit)) begin
              if (ins_moves == '0) begin
                mem_we    = 1'b1;
                wa_i      = req_r.position;
                mem_wdata = req_r.byte_in;
                fin       = 1'b1;
                fin_ok    = 1'b1;
              end else begin
                // Move the tail up, highest byte first.
                rd_idx_nxt = count_r - 1'b1;
                wr_idx_nxt = count_r;
                rem_nxt    = ins_moves;
                up_nxt     = 1'b1;
                state_nxt  = S_SHIFT;
              end
            end else begin
              fin = 1'b1;
            end
          end
          ACT_REMOVE: begin
            if (span_end <= {1'b0, count_r}) begin
              if (rm_moves == '0) begin
                fin    = 1'b1;
                fin_ok = 1'b1;
              end else begin
                // Close the gap, lowest byte first.
                rd_idx_nxt = span_end[FILL_W-1:0];
                wr_idx_nxt = req_r.position;
                rem_nxt    = rm_moves;
                up_nxt     = 1'b0;
                state_nxt  = S_SHIFT;
              end
            end else begin
              fin = 1'b1;
            end
          end
          ACT_CLEAR: begin
            fin    = 1'b1;
            fin_ok = 1'b1;
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end

      S_FETCH: begin
        byte_nxt = mem_rdata;
        if ((req_r.action == ACT_POP) && (rem_r != '0)) begin
          state_nxt = S_SHIFT;
        end else begin
          fin      = 1'b1;
          fin_ok   = 1'b1;
          fin_byte = mem_rdata;
        end
      end

      S_SHIFT: begin
        // Issue one read per cycle; the registered data lands in the next cycle and is
        // written behind the read pointer, so the two never meet.
        if (rem_r != '0) begin
          rd_idx_nxt = up_r ? (rd_idx_r - 1'b1) : (rd_idx_r + 1'b1);
          rem_nxt    = rem_r - 1'b1;
          pend_nxt   = 1'b1;
        end
        if (pend_r) begin
          mem_we     = 1'b1;
          wr_idx_nxt = up_r ? (wr_idx_r - 1'b1) : (wr_idx_r + 1'b1);
        end
        if ((rem_r == '0) && !pend_r) begin
          fin    = 1'b1;
          fin_ok = 1'b1;
          if (up_r) begin
            // Drop the new byte into the opened slot.
            mem_we    = 1'b1;
            wa_i      = req_r.position;
            mem_wdata = req_r.byte_in;
          end
          if (req_r.action == ACT_POP) begin
            fin_byte = byte_r;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin) begin
      state_nxt = S_IDLE;
      count_nxt = fin_ok ? count_succ : count_r;
    end
  end

  assign mem_waddr = AW'(wa_i);
  assign mem_raddr = AW'(rd_i);

  // Result beat toward the output register.
  assign res.valid         = fin;
  assign res.data.ok       = fin_ok;
  assign res.data.byte_out = fin_byte;
  assign res.data.fill     = count_nxt;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Request and mover payload.
  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    rd_idx_r <= rd_idx_nxt;
    wr_idx_r <= wr_idx_nxt;
    rem_r    <= rem_nxt;
    up_r     <= up_nxt;
    byte_r   <= byte_nxt;
  end

endmodule

// ===== hw/rtl/insertable_byte_array.sv =====
// ----------------------------------------------------------------------------
// Insertable byte array
// Ordered byte store with push, pop, get, insert, remove and clear.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single result
// appears on out_data for one cycle under out_valid, in the cycle in which
// busy drops, so a new request may be started in that same cycle. The bytes
// live in one RAM with one write and one read port, and every byte that an
// action moves passes through that RAM one per cycle. Push, clear, any
// rejected request and an insert or remove that moves no byte finish
// straight from the execute state; get and a pop that empties the array
// add one RAM read; any other insert or remove runs the byte mover over
// the n bytes it moves, and any other pop first reads the front byte and
// then moves n bytes (fill minus position for insert, fill minus position
// minus length for remove, fill minus one for pop). No clearing pass
// follows reset. The capacity register may be written whenever busy is low.
// ----------------------------------------------------------------------------
module insertable_byte_array import iba_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_t               in_data,
  output logic              out_valid,
  output out_t              out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [FILL_W-1:0] cfg_data
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [FILL_W-1:0] cap_r;
  logic [FILL_W-1:0] limit;
  logic              out_valid_r;
  out_t              out_data_r;
  ctrl_res_t         res;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;

  // Capacity register.
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_data;
    end
  end

  // Limit in force is the smaller of capacity and the RAM depth.
  assign limit = (32'(cap_r) < 32'(DEPTH)) ? cap_r : FILL_W'(DEPTH);

  iba_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .limit     (limit),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  iba_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register: one result beat per request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_data_r <= res.data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/iba_checker.sv =====
// ----------------------------------------------------------------------------
// Insertable byte array checker
// Port-level properties of the byte array, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module iba_checker import iba_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input out_t out_data
);

  // An accepted request raises busy in the next cycle.
  `IBA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "request accepted but busy stayed low")

  // The result beat comes out exactly when busy drops.
  `IBA_ASSERT_NOW(a_done_result, $fell(busy), out_valid, "busy dropped without a result beat")

  // Results are never back to back.
  `IBA_ASSERT_NEXT(a_result_gap, out_valid, !out_valid, "two result beats in a row")

  // A rejected request returns no data byte.
  `IBA_ASSERT_NOW(a_fail_zero, out_valid && !out_data.ok, out_data.byte_out == '0, "failed result with nonzero byte")

  // The fill never exceeds the RAM depth.
  `IBA_ASSERT_NOW(a_fill_bound, out_valid, 32'(out_data.fill) <= 32'(DEPTH), "fill above depth")

endmodule

bind insertable_byte_array iba_checker #(
  .DEPTH(DEPTH)
) u_iba_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

// ===== sim/insertable_byte_array_tb.sv =====
// ----------------------------------------------------------------------------
// Insertable byte array testbench
// Drives request beats through the start/busy handshake and checks every
// result beat against a cycle-free model of the array kept in the bench.
// Covers the empty, full and out-of-range cases, capacity changes between
// phases, a full-depth fill and a long run of random edit traffic.
// ----------------------------------------------------------------------------
module insertable_byte_array_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import iba_pkg::*;

  localparam int unsigned ARRAY_DEPTH = DEPTH_DEF;
  localparam int unsigned IDLE_LIMIT  = 4000;
  localparam int unsigned TAIL_CYCLES = ARRAY_DEPTH + 16;
  localparam int unsigned PHASE_ITEMS = 90;
  localparam int unsigned MAX_PRINTS  = 40;
  localparam logic [ACT_W-1:0] ACT_BAD_LO = 3'd6;
  localparam logic [ACT_W-1:0] ACT_BAD_HI = 3'd7;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              start;
  logic              busy;
  in_t               in_data;
  logic              out_valid;
  out_t              out_data;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [FILL_W-1:0] cfg_data;

  // Bench copy of the array state.
  logic [BYTE_W-1:0] held_bytes [ARRAY_DEPTH];
  int unsigned       held_count;
  int unsigned       capacity_reg;

  out_t        pending_results [$];
  int unsigned mismatch_count;
  int unsigned idle_cycles;
  bit          no_idle;

  insertable_byte_array #(.DEPTH(ARRAY_DEPTH)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Free-running clock, 10 ns period.
  always #5 clk = ~clk;

  // Applies one request to the bench array and returns the result it yields.
  function automatic out_t apply_request(in_t req);
    out_t        res;
    int unsigned lim;
    int unsigned pos;
    int unsigned len;
    int unsigned i;
    res = '0;
    lim = (capacity_reg < ARRAY_DEPTH) ? capacity_reg : ARRAY_DEPTH;
    pos = req.position;
    len = req.length;
    case (req.action)
      ACT_PUSH: begin
        if (held_count < lim) begin
          held_bytes[held_count] = req.byte_in;
          held_count++;
          res.ok = 1'b1;
        end
      end
      ACT_POP: begin
        if (held_count > 0) begin
          res.byte_out = held_bytes[0];
          for (i = 0; i + 1 < held_count; i++) held_bytes[i] = held_bytes[i+1];
          held_count--;
          res.ok = 1'b1;
        end
      end
      ACT_GET: begin
        if (pos < held_count) begin
          res.byte_out = held_bytes[pos];
          res.ok = 1'b1;
        end
      end
      ACT_INSERT: begin
        if (pos <= held_count && held_count < lim) begin
          for (i = held_count; i > pos; i--) held_bytes[i] = held_bytes[i-1];
          held_bytes[pos] = req.byte_in;
          held_count++;
          res.ok = 1'b1;
        end
      end
      ACT_REMOVE: begin
        if (pos + len <= held_count) begin
          for (i = pos; i + len < held_count; i++) held_bytes[i] = held_bytes[i+len];
          held_count -= len;
          res.ok = 1'b1;
        end
      end
      ACT_CLEAR: begin
        held_count = 0;
        res.ok = 1'b1;
      end
      default: begin
      end
    endcase
    res.fill = FILL_W'(held_count);
    return res;
  endfunction

  function automatic in_t make_request(logic [ACT_W-1:0] act, int unsigned pos,
                                       int unsigned len, logic [BYTE_W-1:0] value);
    in_t req;
    req.action   = act;
    req.position = FILL_W'(pos);
    req.length   = FILL_W'(len);
    req.byte_in  = value;
    return req;
  endfunction

  // Mostly well-formed edits around the current fill, with some noise beats.
  function automatic in_t make_random_request();
    in_t         req;
    int unsigned pick;
    int unsigned pos;
    req.action   = ACT_GET;
    req.position = FILL_W'($urandom_range(0, 511));
    req.length   = FILL_W'($urandom_range(0, 511));
    req.byte_in  = BYTE_W'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    // Keep the fill moderate so that shifts stay short on average.
    if (held_count > 48 && pick >= 40 && pick < 70) pick = pick + 30;
    if (pick < 4) begin
      req.action = ACT_W'($urandom_range(0, 7));
    end else if (pick < 26) begin
      req.action = ACT_PUSH;
    end else if (pick < 46) begin
      req.action   = ACT_INSERT;
      req.position = FILL_W'($urandom_range(0, held_count + 1));
    end else if (pick < 64) begin
      req.action   = ACT_GET;
      req.position = FILL_W'($urandom_range(0, held_count));
    end else if (pick < 80) begin
      req.action = ACT_POP;
    end else if (pick < 98) begin
      pos          = $urandom_range(0, held_count);
      req.action   = ACT_REMOVE;
      req.position = FILL_W'(pos);
      req.length   = FILL_W'($urandom_range(0, held_count - pos + 1));
    end else begin
      req.action = ACT_CLEAR;
    end
    return req;
  endfunction

  function automatic int unsigned pick_gap();
    return no_idle ? 0 : $urandom_range(0, 17);
  endfunction

  // Sends one request beat and records the result it must produce.
  task automatic send_request(in_t req);
    int unsigned gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start   <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (busy);
    pending_results.push_back(apply_request(req));
  endtask

  task automatic send(logic [ACT_W-1:0] act, int unsigned pos, int unsigned len,
                      logic [BYTE_W-1:0] value);
    send_request(make_request(act, pos, len, value));
  endtask

  // Stops sending and waits for every outstanding result beat.
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Capacity changes only while the block is idle.
  task automatic write_capacity(int unsigned value);
    drain_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= FILL_W'(value);
    do @(posedge clk); while (!cfg_ready);
    capacity_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    if (mismatch_count < MAX_PRINTS)
      $display("%0t ns: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Result checker: each result beat is compared with the oldest expectation.
  always @(posedge clk) begin : check_results
    out_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result beat", out_data.fill, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.ok !== want.ok)
          report_mismatch("ok", out_data.ok, want.ok);
        if (out_data.byte_out !== want.byte_out)
          report_mismatch("byte_out", out_data.byte_out, want.byte_out);
        if (out_data.fill !== want.fill)
          report_mismatch("fill", out_data.fill, want.fill);
      end
    end
  end

  // Watchdog: too many cycles in a row with no beat moving ends the run.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL insertable_byte_array");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Pop, get and remove on an empty array, clear, and the unused action codes.
  task automatic test_empty_array();
    send(ACT_POP, 0, 0, 8'h00);
    send(ACT_GET, 0, 0, 8'h00);
    send(ACT_REMOVE, 0, 0, 8'h00);
    send(ACT_REMOVE, 0, 1, 8'h00);
    send(ACT_CLEAR, 0, 0, 8'h00);
    send(ACT_BAD_LO, 0, 0, 8'h00);
    send(ACT_BAD_HI, 511, 511, 8'hFF);
  endtask

  // Insert at both ends, reads and removes in and out of range, pops to empty.
  task automatic test_edit_operations();
    send(ACT_PUSH, 0, 0, 8'h00);
    send(ACT_PUSH, 0, 0, 8'hFF);
    send(ACT_INSERT, 0, 0, 8'h5A);
    send(ACT_INSERT, 3, 0, 8'hA5);
    send(ACT_INSERT, 5, 0, 8'h11);
    send(ACT_GET, 0, 0, 8'h00);
    send(ACT_GET, 3, 0, 8'h00);
    send(ACT_GET, 4, 0, 8'h00);
    send(ACT_GET, 511, 0, 8'h00);
    send(ACT_REMOVE, 1, 0, 8'h00);
    send(ACT_REMOVE, 1, 2, 8'h00);
    send(ACT_REMOVE, 511, 511, 8'h00);
    send(ACT_POP, 0, 0, 8'h00);
    send(ACT_POP, 0, 0, 8'h00);
    send(ACT_POP, 0, 0, 8'h00);
  endtask

  // Full array at a small capacity, capacity lowered below the fill, and zero.
  task automatic test_capacity_limits();
    write_capacity(2);
    send(ACT_PUSH, 0, 0, 8'h81);
    send(ACT_PUSH, 0, 0, 8'h42);
    send(ACT_PUSH, 0, 0, 8'h24);
    send(ACT_INSERT, 0, 0, 8'h18);
    write_capacity(1);
    send(ACT_PUSH, 0, 0, 8'h99);
    send(ACT_POP, 0, 0, 8'h00);
    send(ACT_PUSH, 0, 0, 8'h66);
    send(ACT_POP, 0, 0, 8'h00);
    send(ACT_INSERT, 0, 0, 8'h3C);
    write_capacity(0);
    send(ACT_CLEAR, 0, 0, 8'h00);
    send(ACT_PUSH, 0, 0, 8'h77);
    send(ACT_INSERT, 0, 0, 8'h77);
    write_capacity(511);
    send(ACT_PUSH, 0, 0, 8'hC3);
  endtask

  // Fill every entry, then the longest shifts and a remove of the whole array.
  task automatic test_full_depth();
    write_capacity(ARRAY_DEPTH);
    send(ACT_CLEAR, 0, 0, 8'h00);
    while (held_count < ARRAY_DEPTH) send(ACT_PUSH, 0, 0, BYTE_W'($urandom_range(0, 255)));
    send(ACT_PUSH, 0, 0, 8'hEE);
    send(ACT_INSERT, 0, 0, 8'hEE);
    send(ACT_GET, ARRAY_DEPTH - 1, 0, 8'h00);
    send(ACT_GET, ARRAY_DEPTH, 0, 8'h00);
    send(ACT_POP, 0, 0, 8'h00);
    send(ACT_INSERT, 0, 0, 8'h3D);
    send(ACT_REMOVE, 100, 50, 8'h00);
    send(ACT_REMOVE, 0, held_count, 8'h00);
  endtask

  // Random traffic in phases at different capacities, extremes included.
  task automatic test_random_traffic();
    int unsigned caps [10] = '{256, 511, 0, 1, 2, 17, 300, 64, 255, 256};
    int unsigned ph;
    int unsigned n;
    for (ph = 0; ph < 10; ph++) begin
      write_capacity(caps[ph]);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 29) == 0) no_idle = !no_idle;
        // Now and then hold off until the block has answered everything.
        if ($urandom_range(0, 39) == 0) drain_results();
        send_request(make_random_request());
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_data      = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    held_count   = 0;
    capacity_reg = CAP_RESET;
    mismatch_count = 0;
    idle_cycles  = 0;
    no_idle      = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    test_empty_array();
    test_edit_operations();
    test_capacity_limits();
    test_full_depth();
    test_random_traffic();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS insertable_byte_array");
    end else begin
      $display("FAIL insertable_byte_array");
    end
    $finish;
  end

endmodule
